// ----- rtl/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by the top level and its checker.
package rau_pkg;

	localparam int FIELD_BITS       = 16;
	localparam int DEF_OPERAND_BITS = 16;
	localparam int RES_NUM_BITS     = 32;
	localparam int RES_DEN_BITS     = 31;

	typedef enum logic [2:0] {
		ACT_REDUCE = 3'd0,
		ACT_ADD    = 3'd1,
		ACT_SUB    = 3'd2,
		ACT_MUL    = 3'd3,
		ACT_DIV    = 3'd4,
		ACT_INC    = 3'd5,
		ACT_DEC    = 3'd6,
		ACT_CMP    = 3'd7
	} action_t;

endpackage

// ----- rtl/rau_gcd.sv -----
// Binary gcd unit: one shift or subtract per cycle.
// Standalone, no package dependency.
module rau_gcd #(
	parameter int W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         done,
	output logic [W-1:0] g
);
	localparam int KW = $clog2(W + 1);

	logic [W-1:0]  a_q, b_q, g_q;
	logic [KW-1:0] k_q;
	logic          busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			g_q    <= '0;
			k_q    <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				b_q    <= b;
				k_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				priority if (a_q == '0) begin
					g_q    <= b_q << k_q;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (b_q == '0) begin
					g_q    <= a_q << k_q;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (!a_q[0] && !b_q[0]) begin
					// common factor of two, restored at the end
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q >= b_q) begin
					a_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
		end
	end

	assign done = done_q;
	assign g    = g_q;

endmodule

// ----- rtl/rau_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone, no package dependency.
module rau_div #(
	parameter int W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q, dsr_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W:0]    sh, diff;

	always_comb begin
		sh   = {rem_q, quo_q[W-1]};
		diff = sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= '0;
				quo_q <= dividend;
				dsr_q <= divisor;
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				// top bit of diff is the borrow: set means no subtract
				if (!diff[W]) begin
					rem_q <= diff[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= sh[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/rational_arith_unit.sv -----
// Top level of the rational arithmetic unit: sequencer, shared multiplier and adder.
// Depends on rau_pkg, rau_gcd and rau_div.
//
//  channel | signals                                   | handshake
//  op      | action, left_num/den, right_num/den       | op_valid / op_ready
//  res     | result_num/den, is_less, is_equal, bad... | res_valid / res_ready
//
// One item at a time. Error goes straight to emit; increment, decrement, compare are formed
// in the combine state. Reduce divides both parts by their gcd; add, sub, mul, div first form
// three products. SW = 2*min(OPERAND_BITS,16)+1 is the gcd and divider width.
// Reset clears the sequencer and the output register. A stalled result sits in the output
// register; the next item is taken meanwhile and waits in the emit state until it frees.
module rational_arith_unit #(
	parameter int OPERAND_BITS = rau_pkg::DEF_OPERAND_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    op_valid,
	output logic                                    op_ready,
	input  rau_pkg::action_t                        action,
	input  logic signed [rau_pkg::FIELD_BITS-1:0]   left_num,
	input  logic signed [rau_pkg::FIELD_BITS-1:0]   left_den,
	input  logic signed [rau_pkg::FIELD_BITS-1:0]   right_num,
	input  logic signed [rau_pkg::FIELD_BITS-1:0]   right_den,
	output logic                                    res_valid,
	input  logic                                    res_ready,
	output logic signed [rau_pkg::RES_NUM_BITS-1:0] result_num,
	output logic [rau_pkg::RES_DEN_BITS-1:0]        result_den,
	output logic                                    is_less,
	output logic                                    is_equal,
	output logic                                    bad_operand
);
	import rau_pkg::*;

	localparam int MW = (OPERAND_BITS > FIELD_BITS) ? FIELD_BITS : OPERAND_BITS;
	localparam int PW = 2 * MW;
	localparam int SW = PW + 1;
	localparam int IW = MW + 3;

	typedef struct packed {
		logic          neg;
		logic [MW-1:0] mag;
	} opnd_t;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_COMB, S_GCD, S_DIVN, S_DIVD, S_EMIT
	} state_t;

	function automatic opnd_t split(input logic [FIELD_BITS-1:0] f);
		logic signed [MW:0] x;
		opnd_t              r;
		x     = {((OPERAND_BITS <= FIELD_BITS) ? f[MW-1] : 1'b0), f[MW-1:0]};
		r.neg = x[MW];
		r.mag = r.neg ? MW'(-x) : x[MW-1:0];
		return r;
	endfunction

	function automatic logic [RES_NUM_BITS-1:0] sat_num(input logic neg,
			input logic [SW-1:0] mag);
		logic [63:0] m;
		m = 64'(mag);
		if (neg) begin
			if (m > 64'h8000_0000) m = 64'h8000_0000;
			m = 64'd0 - m;
		end else if (m > 64'h7FFF_FFFF) begin
			m = 64'h7FFF_FFFF;
		end
		return m[RES_NUM_BITS-1:0];
	endfunction

	function automatic logic [RES_DEN_BITS-1:0] sat_den(input logic [SW-1:0] mag);
		logic [63:0] m;
		m = 64'(mag);
		if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
		return m[RES_DEN_BITS-1:0];
	endfunction

	state_t  state_q;
	action_t act_q;
	opnd_t   ln_q, ld_q, rn_q, rd_q;
	opnd_t   in_ln, in_ld, in_rn, in_rd;
	logic    [1:0] mstep_q;
	logic    [PW-1:0] p1_q, p2_q, p3_q;
	logic    s1_q, s2_q, s3_q;
	logic    num_neg_q, den_neg_q;
	logic    [SW-1:0] num_mag_q, nq_q;
	logic    [PW-1:0] den_mag_q;
	logic    go_q;
	logic    [RES_NUM_BITS-1:0] fin_num_q;
	logic    [RES_DEN_BITS-1:0] fin_den_q;
	logic    fin_less_q, fin_eq_q, fin_bad_q;
	logic    res_valid_q, less_q, eq_q, bad_q;
	logic    [RES_NUM_BITS-1:0] res_num_q;
	logic    [RES_DEN_BITS-1:0] res_den_q;

	logic    in_err, uses_right;
	opnd_t   ma, mb;
	logic    [PW-1:0] mprod;
	logic    mneg;
	logic    b_neg, sum_neg, fin_neg;
	logic    [SW-1:0] e1, e2, sum_mag;
	logic    signed [SW-1:0] ps, qs;
	logic    signed [IW-1:0] sl, sd, iv;
	logic    gcd_start, gcd_done, div_start, div_done;
	logic    [SW-1:0] gcd_g, div_num, div_quo;

	assign in_ln = split(left_num);
	assign in_ld = split(left_den);
	assign in_rn = split(right_num);
	assign in_rd = split(right_den);

	always_comb begin
		uses_right = (action == ACT_ADD) || (action == ACT_SUB) || (action == ACT_MUL) ||
		             (action == ACT_DIV) || (action == ACT_CMP);
		in_err     = (in_ld.mag == '0) || (uses_right && in_rd.mag == '0) ||
		             (action == ACT_DIV && in_rn.mag == '0);
	end

	// shared multiplier, one cross product per cycle
	always_comb begin
		unique case (mstep_q)
			2'd0: begin
				ma = ln_q;
				mb = (act_q == ACT_MUL) ? rn_q : rd_q;
			end
			2'd1: begin
				ma = rn_q;
				mb = ld_q;
			end
			default: begin
				ma = ld_q;
				mb = (act_q == ACT_DIV) ? rn_q : rd_q;
			end
		endcase
		mprod = PW'(ma.mag) * PW'(mb.mag);
		mneg  = ma.neg ^ mb.neg;
	end

	// sign-magnitude add, compare and the unreduced increment and decrement
	always_comb begin
		b_neg = s2_q ^ (act_q == ACT_SUB);
		e1    = {1'b0, p1_q};
		e2    = {1'b0, p2_q};
		if (s1_q == b_neg) begin
			sum_mag = e1 + e2;
			sum_neg = s1_q;
		end else if (e1 >= e2) begin
			sum_mag = e1 - e2;
			sum_neg = s1_q;
		end else begin
			sum_mag = e2 - e1;
			sum_neg = b_neg;
		end
		ps = (ln_q.neg ^ ld_q.neg) ? -$signed(e1) : $signed(e1);
		qs = (rn_q.neg ^ rd_q.neg) ? -$signed(e2) : $signed(e2);
		sl = ln_q.neg ? -$signed(IW'(ln_q.mag)) : $signed(IW'(ln_q.mag));
		sd = ld_q.neg ? -$signed(IW'(ld_q.mag)) : $signed(IW'(ld_q.mag));
		iv = (act_q == ACT_INC) ? sl + sd : sl - sd;
		if (ld_q.neg) iv = -iv;
		fin_neg = (num_neg_q != den_neg_q) && (nq_q != '0);
	end

	assign gcd_start = go_q && (state_q == S_GCD);
	assign div_start = go_q && (state_q == S_DIVN || state_q == S_DIVD);
	assign div_num   = (state_q == S_DIVN) ? num_mag_q : SW'(den_mag_q);

	rau_gcd #(.W(SW)) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (SW'(den_mag_q)),
		.b      (num_mag_q),
		.done   (gcd_done),
		.g      (gcd_g)
	);

	rau_div #(.W(SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (gcd_g),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= ACT_REDUCE;
			ln_q        <= '0;
			ld_q        <= '0;
			rn_q        <= '0;
			rd_q        <= '0;
			mstep_q     <= '0;
			p1_q        <= '0;
			p2_q        <= '0;
			p3_q        <= '0;
			s1_q        <= 1'b0;
			s2_q        <= 1'b0;
			s3_q        <= 1'b0;
			num_neg_q   <= 1'b0;
			den_neg_q   <= 1'b0;
			num_mag_q   <= '0;
			den_mag_q   <= '0;
			nq_q        <= '0;
			go_q        <= 1'b0;
			fin_num_q   <= '0;
			fin_den_q   <= '0;
			fin_less_q  <= 1'b0;
			fin_eq_q    <= 1'b0;
			fin_bad_q   <= 1'b0;
			res_valid_q <= 1'b0;
			res_num_q   <= '0;
			res_den_q   <= '0;
			less_q      <= 1'b0;
			eq_q        <= 1'b0;
			bad_q       <= 1'b0;
		end else begin
			go_q <= 1'b0;
			// the emit state reloads the output itself
			if (res_valid_q && res_ready && state_q != S_EMIT) res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						act_q      <= action;
						ln_q       <= in_ln;
						ld_q       <= in_ld;
						rn_q       <= in_rn;
						rd_q       <= in_rd;
						mstep_q    <= '0;
						fin_num_q  <= '0;
						fin_den_q  <= '0;
						fin_less_q <= 1'b0;
						fin_eq_q   <= 1'b0;
						fin_bad_q  <= in_err;
						priority if (in_err) begin
							state_q <= S_EMIT;
						end else if (action == ACT_REDUCE || action == ACT_INC ||
								action == ACT_DEC) begin
							state_q <= S_COMB;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					unique case (mstep_q)
						2'd0: begin
							p1_q <= mprod;
							s1_q <= mneg;
						end
						2'd1: begin
							p2_q <= mprod;
							s2_q <= mneg;
						end
						default: begin
							p3_q <= mprod;
							s3_q <= mneg;
						end
					endcase
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 2'd2) state_q <= S_COMB;
				end
				S_COMB: begin
					unique case (act_q)
						ACT_REDUCE: begin
							num_mag_q <= SW'(ln_q.mag);
							num_neg_q <= ln_q.neg;
							den_mag_q <= PW'(ld_q.mag);
							den_neg_q <= ld_q.neg;
							state_q   <= S_GCD;
							go_q      <= 1'b1;
						end
						ACT_ADD, ACT_SUB: begin
							num_mag_q <= sum_mag;
							num_neg_q <= sum_neg;
							den_mag_q <= p3_q;
							den_neg_q <= s3_q;
							state_q   <= S_GCD;
							go_q      <= 1'b1;
						end
						ACT_MUL, ACT_DIV: begin
							num_mag_q <= e1;
							num_neg_q <= s1_q;
							den_mag_q <= p3_q;
							den_neg_q <= s3_q;
							state_q   <= S_GCD;
							go_q      <= 1'b1;
						end
						ACT_INC, ACT_DEC: begin
							fin_num_q <= RES_NUM_BITS'(iv);
							fin_den_q <= RES_DEN_BITS'(ld_q.mag);
							state_q   <= S_EMIT;
						end
						ACT_CMP: begin
							fin_less_q <= (ps < qs);
							fin_eq_q   <= (ps == qs);
							state_q    <= S_EMIT;
						end
					endcase
				end
				S_GCD: begin
					if (gcd_done) begin
						state_q <= S_DIVN;
						go_q    <= 1'b1;
					end
				end
				S_DIVN: begin
					if (div_done) begin
						nq_q    <= div_quo;
						state_q <= S_DIVD;
						go_q    <= 1'b1;
					end
				end
				S_DIVD: begin
					if (div_done) begin
						fin_num_q <= sat_num(fin_neg, nq_q);
						fin_den_q <= sat_den(div_quo);
						state_q   <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						res_num_q   <= fin_num_q;
						res_den_q   <= fin_den_q;
						less_q      <= fin_less_q;
						eq_q        <= fin_eq_q;
						bad_q       <= fin_bad_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign op_ready    = (state_q == S_IDLE);
	assign res_valid   = res_valid_q;
	assign result_num  = res_num_q;
	assign result_den  = res_den_q;
	assign is_less     = less_q;
	assign is_equal    = eq_q;
	assign bad_operand = bad_q;

endmodule

// ----- rtl/rau_checker.sv -----
// Port-level checks for rational_arith_unit, attached by bind.
// Depends on rau_pkg.
module rau_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    op_valid,
	input logic                                    op_ready,
	input rau_pkg::action_t                        action,
	input logic signed [rau_pkg::FIELD_BITS-1:0]   left_num,
	input logic signed [rau_pkg::FIELD_BITS-1:0]   left_den,
	input logic signed [rau_pkg::FIELD_BITS-1:0]   right_num,
	input logic signed [rau_pkg::FIELD_BITS-1:0]   right_den,
	input logic                                    res_valid,
	input logic                                    res_ready,
	input logic signed [rau_pkg::RES_NUM_BITS-1:0] result_num,
	input logic [rau_pkg::RES_DEN_BITS-1:0]        result_den,
	input logic                                    is_less,
	input logic                                    is_equal,
	input logic                                    bad_operand
);
	import rau_pkg::*;

	// errors carry all-zero payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && bad_operand |-> result_num == '0 && result_den == '0 &&
		!is_less && !is_equal)
		else $error("error result with non-zero payload");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(is_less && is_equal))
		else $error("less and equal both set");

	// zero denominator only for compare or error, both with zero numerator
	a_den_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_den == '0 |-> result_num == '0)
		else $error("zero denominator with non-zero numerator");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op_ready |=> !op_ready)
		else $error("second transfer taken while busy");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(result_num) &&
		$stable(result_den))
		else $error("stalled result changed");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);

// ----- dv/rational_arith_unit_tb.sv -----
// Self-checking bench for rational_arith_unit: directed corners, then random fractions.
// Depends on rau_pkg and the RTL; a scoreboard class predicts every result.
`timescale 1ns / 1ps

class rau_scoreboard;
	typedef struct {
		logic signed [31:0] num;
		logic [30:0]        den;
		logic               lt;
		logic               eq;
		logic               bad;
	} frac_res_t;

	frac_res_t pending[$];
	int        errors;
	int        checked;

	static function longint unsigned gcd_of(longint unsigned a, longint unsigned b);
		longint unsigned t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// sign folded into the numerator, both fields saturated
	static function void fold(bit nneg, longint unsigned nm, bit dneg, longint unsigned dm,
			bit do_reduce, output frac_res_t r);
		longint unsigned g;
		if (do_reduce) begin
			g = gcd_of(dm, nm);
			if (g == 0) g = 1;
			nm = nm / g;
			dm = dm / g;
		end
		if (nneg != dneg && nm != 0) begin
			if (nm > 64'h8000_0000) nm = 64'h8000_0000;
			r.num = -nm;
		end else begin
			if (nm > 64'h7FFF_FFFF) nm = 64'h7FFF_FFFF;
			r.num = nm;
		end
		if (dm > 64'h7FFF_FFFF) dm = 64'h7FFF_FFFF;
		r.den = dm;
	endfunction

	static function longint unsigned mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function void note_operands(rau_pkg::action_t act, shortint ln, shortint ld,
			shortint rn, shortint rd);
		frac_res_t r;
		longint    n, d, p, q, a, b, c, e;
		bit        right_used;
		r = '{default: '0};
		right_used = act inside {rau_pkg::ACT_ADD, rau_pkg::ACT_SUB, rau_pkg::ACT_MUL,
			rau_pkg::ACT_DIV, rau_pkg::ACT_CMP};
		if (ld == 0 || (right_used && rd == 0) || (act == rau_pkg::ACT_DIV && rn == 0)) begin
			r.bad = 1'b1;
		end else begin
			case (act)
				rau_pkg::ACT_REDUCE: begin
					n = ln; d = ld;
				end
				rau_pkg::ACT_ADD: begin
					n = longint'(ln) * rd + longint'(rn) * ld; d = longint'(ld) * rd;
				end
				rau_pkg::ACT_SUB: begin
					n = longint'(ln) * rd - longint'(rn) * ld; d = longint'(ld) * rd;
				end
				rau_pkg::ACT_MUL: begin
					n = longint'(ln) * rn; d = longint'(ld) * rd;
				end
				rau_pkg::ACT_DIV: begin
					n = longint'(ln) * rd; d = longint'(ld) * rn;
				end
				rau_pkg::ACT_INC: begin
					n = longint'(ln) + ld; d = ld;
				end
				rau_pkg::ACT_DEC: begin
					n = longint'(ln) - ld; d = ld;
				end
				default: begin
					a = ln; b = ld; c = rn; e = rd;
					if (b < 0) begin a = -a; b = -b; end
					if (e < 0) begin c = -c; e = -e; end
					p = a * e;
					q = c * b;
					r.lt = p < q;
					r.eq = p == q;
				end
			endcase
			if (act != rau_pkg::ACT_CMP)
				fold(n < 0, mag(n), d < 0, mag(d),
					!(act inside {rau_pkg::ACT_INC, rau_pkg::ACT_DEC}), r);
		end
		pending.push_back(r);
	endfunction

	function void check_result(logic signed [31:0] num, logic [30:0] den, logic lt, logic eq,
			logic bad);
		frac_res_t x;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result num=%0d den=%0d", $time, num, den);
			errors++;
			return;
		end
		x = pending.pop_front();
		checked++;
		if (num !== x.num) begin
			$display("%0t: result_num exp %0d got %0d", $time, x.num, num); errors++;
		end
		if (den !== x.den) begin
			$display("%0t: result_den exp %0d got %0d", $time, x.den, den); errors++;
		end
		if (lt !== x.lt) begin
			$display("%0t: is_less exp %0b got %0b", $time, x.lt, lt); errors++;
		end
		if (eq !== x.eq) begin
			$display("%0t: is_equal exp %0b got %0b", $time, x.eq, eq); errors++;
		end
		if (bad !== x.bad) begin
			$display("%0t: bad_operand exp %0b got %0b", $time, x.bad, bad); errors++;
		end
	endfunction
endclass

module rational_arith_unit_tb;
	import rau_pkg::*;

	localparam int N_RANDOM = 1000;
	localparam int STALL_LIMIT = 20000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               op_valid = 1'b0;
	logic               op_ready;
	action_t            action = ACT_REDUCE;
	logic signed [15:0] left_num = '0, left_den = '0, right_num = '0, right_den = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	logic signed [31:0] result_num;
	logic [30:0]        result_den;
	logic               is_less, is_equal, bad_operand;

	rau_scoreboard sb = new();
	bit  stim_done = 1'b0;
	bit  long_hold = 1'b0;
	int  idle_cycles = 0;
	int  sent = 0;

	rational_arith_unit dut (.*);

	always #4 clk = ~clk;

	// valid stays up after a transfer; it drops only when a gap follows
	task automatic send_op(action_t a, shortint ln, shortint ld, shortint rn, shortint rd);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_valid  <= 1'b1;
		action    <= a;
		left_num  <= ln;
		left_den  <= ld;
		right_num <= rn;
		right_den <= rd;
		do @(posedge clk); while (!op_ready);
		sb.note_operands(a, ln, ld, rn, rd);
		sent++;
	endtask

	function automatic shortint pick_field();
		case ($urandom_range(0, 5))
			0:       return shortint'(int'($urandom_range(0, 2)) - 1);
			1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			2:       return shortint'(int'($urandom_range(0, 24)) - 12);
			default: return shortint'($urandom());
		endcase
	endfunction

	// result side: random back-pressure, one long hold-off on request
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				res_ready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end
			wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
			if (wait_n > 0) begin
				res_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			sb.check_result(result_num, result_den, is_less, is_equal, bad_operand);
		end
	end

	always @(posedge clk) begin
		if ((op_valid && op_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		action_t a;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: every action, zero denominators, zero divisor, extremes
		for (int i = 0; i < 8; i++) begin
			a = action_t'(i);
			send_op(a, -16'sd6, -16'sd4, 16'sd3, 16'sd9);
		end
		send_op(ACT_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_op(ACT_MUL, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
		send_op(ACT_SUB, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
		send_op(ACT_DIV, 16'sh8000, 16'sd1, 16'sd1, 16'sh8000);
		send_op(ACT_DIV, 16'sd5, 16'sd3, 16'sd0, 16'sd7);
		send_op(ACT_REDUCE, 16'sd4, 16'sd0, 16'sd1, 16'sd1);
		send_op(ACT_INC, 16'sd4, 16'sd3, 16'sd1, 16'sd0);
		send_op(ACT_DEC, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0);
		send_op(ACT_CMP, 16'sd1, 16'sd2, 16'sd1, 16'sd0);
		send_op(ACT_CMP, 16'sd1, 16'sd2, -16'sd2, -16'sd4);
		send_op(ACT_CMP, 16'sd1, -16'sd2, 16'sd0, 16'sd5);
		send_op(ACT_ADD, 16'sd0, -16'sd7, 16'sd0, 16'sd3);
		send_op(ACT_REDUCE, 16'sd0, -16'sd9, 16'sd0, 16'sd0);
		send_op(ACT_INC, 16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0);
		op_valid <= 1'b0;

		// pause until the unit has drained
		wait (sb.pending.size() == 0);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) long_hold = 1'b1;
			a = action_t'($urandom_range(0, 7));
			send_op(a, pick_field(), pick_field(), pick_field(), pick_field());
		end
		op_valid <= 1'b0;
		stim_done = 1'b1;

		wait (sb.pending.size() == 0);
		repeat (400) @(posedge clk);
		$display("Sent %0d operations over all eight actions, %0d results checked.",
			sent, sb.checked);
		$display("Covered zero and negative denominators, zero divisors and field extremes.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
